@@ design/stat_pkg.sv @@
// ----------------------------------------------------------------------------
// stat_pkg
// Shared types, codes and helpers for the section table address translator.
// ----------------------------------------------------------------------------
package stat_pkg;

  localparam int unsigned MAX_SECTIONS_DEF = 16;
  localparam int unsigned NAME_BYTES       = 8;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 32;
  localparam int unsigned COUNT_W          = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_COUNT = 2'd1;

  typedef enum logic [2:0] {
    CMD_WRITE     = 3'd0,
    CMD_TO_FILE   = 3'd1,
    CMD_TO_IMAGE  = 3'd2,
    CMD_FIND_ADDR = 3'd3,
    CMD_FIND_NAME = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_TEST,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_HEADER,
    RES_HIT
  } res_sel_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  entry_index;
    logic [31:0] address;
    logic [63:0] section_name;
    logic [31:0] entry_virtual_address;
    logic [31:0] entry_virtual_size;
    logic [31:0] entry_raw_size;
    logic [31:0] entry_raw_pointer;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic        in_header;
    logic [3:0]  section_index;
    logic [31:0] result_address;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic     capture;
    logic     mem_write;
    logic     idx_clear;
    logic     idx_incr;
    logic     mem_read;
    logic     rsl_load;
    res_sel_e rsl_sel;
    logic     out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_write;
    logic is_query;
    logic hdr_hit;
    logic scan_done;
    logic hit;
  } dp_status_t;

  // byte-wise compare, a NUL in both query and stored name ends it as a match
  function automatic logic name_match(input logic [63:0] stored,
                                      input logic [63:0] query);
    logic       match;
    logic       stop;
    logic [7:0] q;
    logic [7:0] s;
    match = 1'b1;
    stop  = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      q = query[8*i +: 8];
      s = stored[8*i +: 8];
      if (!stop) begin
        if (q != s) begin
          match = 1'b0;
          stop  = 1'b1;
        end else if (q == 8'd0) begin
          stop = 1'b1;
        end
      end
    end
    return match;
  endfunction

endpackage

@@ design/section_table_address_translator_core.sv @@
// ----------------------------------------------------------------------------
// section_table_address_translator_core
// Section table with image/file address translation and section lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) takes one command
//   item at a time: write a table slot, translate image-relative to file
//   offset or back, find the section holding an address, or find by name.
//   Every item yields exactly one result item on out_valid_o / out_ready_i /
//   out_item_o; a write yields an all-zero acknowledge.
//   Config channel (cfg_valid_i / cfg_ready_o) sets header_size (index 0)
//   and section_count (index 1); always ready, write only while idle.
// Sequencing:
//   The table is scanned one slot at a time through a registered memory
//   read: each slot is read in ST_READ and tested in ST_TEST. A write, a
//   header pass-through or an unknown command skips the scan; a search ends
//   at the first hit or after section_count slots (capped at MAX_SECTIONS).
//   With the output free, the result goes valid at the same edge the
//   controller returns to idle.
// Reset: config registers clear to zero, controller idles, no result is
//   pending. Table contents are undefined until written.
// Stall: the output register holds a result until taken; the next item is
//   accepted meanwhile, and its result waits in a staging register.
// ----------------------------------------------------------------------------
module section_table_address_translator_core #(
  parameter int unsigned MAX_SECTIONS = stat_pkg::MAX_SECTIONS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  stat_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output stat_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [stat_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [stat_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import stat_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // config writes land the same cycle, no backpressure
  assign cfg_ready_o = 1'b1;

  stat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  stat_datapath #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_item_o  (out_item_o)
  );

endmodule

@@ design/stat_ctrl.sv @@
// ----------------------------------------------------------------------------
// stat_ctrl
// Sequencer: decodes an item, steps the table scan, hands off the result.
// ----------------------------------------------------------------------------
module stat_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  stat_pkg::dp_status_t status_i,
  output stat_pkg::dp_cmd_t   cmd_o
);
  import stat_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.rsl_sel = RES_ZERO;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status_i.is_write) begin
          cmd_o.mem_write = 1'b1;
          cmd_o.rsl_load  = 1'b1;
          state_d         = ST_DONE;
        end else if (status_i.hdr_hit) begin
          cmd_o.rsl_load = 1'b1;
          cmd_o.rsl_sel  = RES_HEADER;
          state_d        = ST_DONE;
        end else if (status_i.is_query) begin
          cmd_o.idx_clear = 1'b1;
          state_d         = ST_READ;
        end else begin
          cmd_o.rsl_load = 1'b1;
          state_d        = ST_DONE;
        end
      end
      ST_READ: begin
        if (status_i.scan_done) begin
          cmd_o.rsl_load = 1'b1;
          state_d        = ST_DONE;
        end else begin
          cmd_o.mem_read = 1'b1;
          state_d        = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status_i.hit) begin
          cmd_o.rsl_load = 1'b1;
          cmd_o.rsl_sel  = RES_HIT;
          state_d        = ST_DONE;
        end else begin
          cmd_o.idx_incr = 1'b1;
          state_d        = ST_READ;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/stat_datapath.sv @@
// ----------------------------------------------------------------------------
// stat_datapath
// Item register, section table memory, range/name compare and result regs.
// ----------------------------------------------------------------------------
module stat_datapath #(
  parameter int unsigned MAX_SECTIONS = stat_pkg::MAX_SECTIONS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  stat_pkg::in_item_t                  in_item_i,
  input  logic                                cfg_we_i,
  input  logic [stat_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [stat_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  stat_pkg::dp_cmd_t                   cmd_i,
  output stat_pkg::dp_status_t                status_o,
  output stat_pkg::out_item_t                 out_item_o
);
  import stat_pkg::*;

  localparam int unsigned IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SECTIONS + 1);

  // config
  logic [31:0]        hdr_size_q;
  logic [COUNT_W-1:0] sec_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_size_q  <= '0;
      sec_count_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_HEADER_SIZE) begin
        hdr_size_q <= cfg_data_i[31:0];
      end else if (cfg_index_i == REG_SECTION_COUNT) begin
        sec_count_q <= cfg_data_i[COUNT_W-1:0];
      end
    end
  end

  // item register
  in_item_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
  end

  // section table
  logic [63:0] names_mem  [MAX_SECTIONS];
  logic [31:0] vstart_mem [MAX_SECTIONS];
  logic [31:0] vsize_mem  [MAX_SECTIONS];
  logic [31:0] rsize_mem  [MAX_SECTIONS];
  logic [31:0] rstart_mem [MAX_SECTIONS];

  logic [31:0]      slot_ext;
  logic [IDX_W-1:0] wr_addr;
  logic             slot_ok;

  assign slot_ext = 32'(item_q.entry_index);
  assign wr_addr  = slot_ext[IDX_W-1:0];
  assign slot_ok  = slot_ext < 32'(MAX_SECTIONS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write && slot_ok) begin
      names_mem[wr_addr]  <= item_q.section_name;
      vstart_mem[wr_addr] <= item_q.entry_virtual_address;
      vsize_mem[wr_addr]  <= item_q.entry_virtual_size;
      rsize_mem[wr_addr]  <= item_q.entry_raw_size;
      rstart_mem[wr_addr] <= item_q.entry_raw_pointer;
    end
  end

  // scan index
  logic [CNT_W-1:0] idx_q;
  logic [31:0]      idx_ext;
  logic [31:0]      active_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clear) begin
      idx_q <= '0;
    end else if (cmd_i.idx_incr) begin
      idx_q <= idx_q + CNT_W'(1);
    end
  end

  assign idx_ext  = 32'(idx_q);
  assign active_n = (32'(sec_count_q) > 32'(MAX_SECTIONS)) ? 32'(MAX_SECTIONS)
                                                           : 32'(sec_count_q);

  // registered table read
  logic [63:0] rd_name_q;
  logic [31:0] rd_vstart_q, rd_vsize_q, rd_rsize_q, rd_rstart_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_read) begin
      rd_name_q   <= names_mem[idx_q[IDX_W-1:0]];
      rd_vstart_q <= vstart_mem[idx_q[IDX_W-1:0]];
      rd_vsize_q  <= vsize_mem[idx_q[IDX_W-1:0]];
      rd_rsize_q  <= rsize_mem[idx_q[IDX_W-1:0]];
      rd_rstart_q <= rstart_mem[idx_q[IDX_W-1:0]];
    end
  end

  // compare
  logic        to_image;
  logic        find_addr;
  logic        find_name;
  logic [31:0] base;
  logic [31:0] size;
  logic [31:0] rebase;
  logic [32:0] range_end;
  logic        range_hit;
  logic [31:0] xlat;

  assign to_image  = item_q.cmd == CMD_TO_IMAGE;
  assign find_addr = item_q.cmd == CMD_FIND_ADDR;
  assign find_name = item_q.cmd == CMD_FIND_NAME;
  assign base      = to_image  ? rd_rstart_q : rd_vstart_q;
  assign rebase    = to_image  ? rd_vstart_q : rd_rstart_q;
  assign size      = find_addr ? rd_vsize_q  : rd_rsize_q;
  assign range_end = {1'b0, base} + {1'b0, size};   // 33 bits, no wrap
  assign range_hit = (item_q.address >= base) && ({1'b0, item_q.address} < range_end);
  assign xlat      = item_q.address - base + rebase;

  assign status_o.is_write  = item_q.cmd == CMD_WRITE;
  assign status_o.is_query  = (item_q.cmd == CMD_TO_FILE) || to_image || find_addr
                              || find_name;
  assign status_o.hdr_hit   = ((item_q.cmd == CMD_TO_FILE) || to_image)
                              && (item_q.address < hdr_size_q);
  assign status_o.scan_done = idx_ext >= active_n;
  assign status_o.hit       = find_name ? name_match(rd_name_q, item_q.section_name)
                                        : range_hit;

  // result staging and output registers
  out_item_t rsl_d;
  out_item_t rsl_q;
  out_item_t out_q;

  always_comb begin
    rsl_d = '0;
    case (cmd_i.rsl_sel)
      RES_HEADER: begin
        rsl_d.found          = 1'b1;
        rsl_d.in_header      = 1'b1;
        rsl_d.result_address = item_q.address;
      end
      RES_HIT: begin
        rsl_d.found         = 1'b1;
        rsl_d.section_index = idx_ext[3:0];
        if (!find_addr && !find_name) begin
          rsl_d.result_address = xlat;
        end
      end
      default: begin
        rsl_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsl_load) begin
      rsl_q <= rsl_d;
    end
    if (cmd_i.out_load) begin
      out_q <= rsl_q;
    end
  end

  assign out_item_o = out_q;

endmodule
